### design/irf_pkg.sv
package irf_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_FIELD_DEF  = 60;
    localparam int OUT_LIMIT      = 64;
    localparam int RADIX_MAX      = 16;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;
    localparam logic [1:0] SIGN_MINUS = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic              bad;
        logic [4:0]        base;
        logic [5:0]        width;
        logic signed [6:0] prec;
        logic              alt;
        logic              left;
        logic              zfill;
        logic              upper;
        logic [7:0]        sign_ch;
        logic              val_zero;
    } t_desc;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DIV,
        PH_PLAN_A,
        PH_PLAN_B,
        PH_EMIT
    } t_phase;

    function automatic logic [7:0] sign_char(input logic [1:0] sel);
        logic [7:0] c;
        case (sel)
            SIGN_NONE:  c = CH_NUL;
            SIGN_PLUS:  c = CH_PLUS;
            SIGN_SPACE: c = CH_SPACE;
            SIGN_MINUS: c = CH_MINUS;
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + 8'(d);
        end else begin
            c = (upper ? CH_UA : CH_LA) + 8'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

### design/irf_front.sv
module irf_front import irf_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [63:0]           i_magnitude,
    input  logic [4:0]            i_radix,
    input  logic [5:0]            i_min_width,
    input  logic signed [6:0]     i_digits_min,
    input  logic                  i_alt_form,
    input  logic                  i_left_justify,
    input  logic                  i_zero_fill,
    input  logic                  i_upper_case,
    input  logic [1:0]            i_sign_select,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output logic [VALUE_BITS-1:0] o_value,
    output t_desc                 o_desc
);

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign o_value = i_magnitude[VALUE_BITS-1:0];

    always_comb begin
        o_desc          = '0;
        o_desc.bad      = i_radix < 5'd2;
        o_desc.base     = (i_radix > 5'(RADIX_MAX)) ? 5'(RADIX_MAX) : i_radix;
        o_desc.width    = (i_min_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_min_width;
        if (i_digits_min[6]) begin
            o_desc.prec = '1;
        end else if (i_digits_min > 7'(MAX_FIELD)) begin
            o_desc.prec = 7'(MAX_FIELD);
        end else begin
            o_desc.prec = i_digits_min;
        end
        o_desc.alt      = i_alt_form;
        o_desc.left     = i_left_justify;
        o_desc.zfill    = i_zero_fill;
        o_desc.upper    = i_upper_case;
        o_desc.sign_ch  = sign_char(i_sign_select);
        o_desc.val_zero = o_value == '0;
    end

endmodule

### design/irf_queue.sv
module irf_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/irf_digit_div.sv
module irf_digit_div import irf_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [4:0]            i_base,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quot,
    output logic [3:0]            o_rem
);

    localparam int STEP = 4;
    localparam int ITER = (VALUE_BITS + STEP - 1) / STEP;
    localparam int DW   = ITER * STEP;
    localparam int CW   = $clog2(ITER);

    logic [DW-1:0] r_work;
    logic [4:0]    r_rem;
    logic [4:0]    r_base;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] n_work;
    logic [4:0]    n_rem;

    always_comb begin
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < STEP; k++) begin
            n_rem  = {n_rem[3:0], n_work[DW-1]};
            n_work = {n_work[DW-2:0], 1'b0};
            if (n_rem >= r_base) begin
                n_rem     = n_rem - r_base;
                n_work[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= DW'(i_dividend);
            r_rem  <= '0;
            r_base <= i_base;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work[VALUE_BITS-1:0];
    assign o_rem  = r_rem[3:0];

endmodule

### design/irf_back.sv
module irf_back import irf_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  logic [VALUE_BITS-1:0] i_q_value,
    input  t_desc                 i_q_desc,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_char_code,
    output logic                  o_char_valid,
    output logic                  o_last_char,
    output logic                  o_bad_radix
);

    localparam int DEPTH = VALUE_BITS;
    localparam int DCW   = $clog2(VALUE_BITS + 1);
    localparam int SW    = 4 * DEPTH;

    t_phase                r_phase, n_phase;
    t_desc                 r_desc, n_desc;
    logic [SW-1:0]         r_stack, n_stack;
    logic [DCW-1:0]        r_dc, n_dc;
    logic [5:0]            r_lcnt, n_lcnt;
    logic [5:0]            r_zcnt, n_zcnt;
    logic [5:0]            r_rcnt, n_rcnt;
    logic                  r_sign_pend, n_sign_pend;
    logic [1:0]            r_pfx, n_pfx;
    logic [7:0]            r_content, n_content;
    logic [6:0]            r_left, n_left;
    logic                  r_special, n_special;
    logic                  r_ov, n_ov;
    logic [7:0]            r_code, n_code;
    logic                  r_cv, n_cv;
    logic                  r_last, n_last;
    logic                  r_bad, n_bad;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_in;
    logic [4:0]            div_base;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [3:0]            div_rem;

    logic [7:0]            dc8;
    logic [7:0]            prec8;
    logic [7:0]            zpad8;
    logic [7:0]            width8;
    logic [7:0]            pad8;
    logic [7:0]            total8;
    logic                  slot_free;

    irf_digit_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_base     (div_base),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign slot_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc      <= n_desc;
        r_stack     <= n_stack;
        r_dc        <= n_dc;
        r_lcnt      <= n_lcnt;
        r_zcnt      <= n_zcnt;
        r_rcnt      <= n_rcnt;
        r_sign_pend <= n_sign_pend;
        r_pfx       <= n_pfx;
        r_content   <= n_content;
        r_left      <= n_left;
        r_special   <= n_special;
        r_code      <= n_code;
        r_cv        <= n_cv;
        r_last      <= n_last;
        r_bad       <= n_bad;
    end

    always_comb begin
        n_phase     = r_phase;
        n_desc      = r_desc;
        n_stack     = r_stack;
        n_dc        = r_dc;
        n_lcnt      = r_lcnt;
        n_zcnt      = r_zcnt;
        n_rcnt      = r_rcnt;
        n_sign_pend = r_sign_pend;
        n_pfx       = r_pfx;
        n_content   = r_content;
        n_left      = r_left;
        n_special   = r_special;
        n_ov        = r_ov && !i_ready;
        n_code      = r_code;
        n_cv        = r_cv;
        n_last      = r_last;
        n_bad       = r_bad;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        div_in      = i_q_value;
        div_base    = r_desc.base;
        dc8         = 8'(r_dc);
        prec8       = {r_desc.prec[6], r_desc.prec};
        zpad8       = '0;
        width8      = 8'(r_desc.width);
        pad8        = '0;
        total8      = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_desc      = i_q_desc;
                    n_dc        = '0;
                    n_lcnt      = '0;
                    n_zcnt      = '0;
                    n_rcnt      = '0;
                    n_pfx       = '0;
                    n_sign_pend = 1'b0;
                    n_special   = 1'b0;
                    if (i_q_desc.bad) begin
                        n_special = 1'b1;
                        n_left    = 7'd1;
                        n_phase   = PH_EMIT;
                    end else if (i_q_desc.val_zero && i_q_desc.prec == '0) begin
                        n_phase = PH_PLAN_A;
                    end else begin
                        div_start = 1'b1;
                        div_base  = i_q_desc.base;
                        n_phase   = PH_DIV;
                    end
                end
            end
            PH_DIV: begin
                if (div_done) begin
                    n_stack = {r_stack[SW-5:0], div_rem};
                    n_dc    = r_dc + DCW'(1);
                    if (div_quot == '0 || r_dc == DCW'(DEPTH - 1)) begin
                        n_phase = PH_PLAN_A;
                    end else begin
                        div_start = 1'b1;
                        div_in    = div_quot;
                    end
                end
            end
            PH_PLAN_A: begin
                if (r_desc.alt && r_desc.base == 5'd16 && !r_desc.val_zero) begin
                    n_pfx = 2'd2;
                end
                if (r_desc.alt && r_desc.base == 5'd8 && !(r_dc != '0 && r_desc.val_zero)
                        && $signed(prec8) <= $signed(dc8)) begin
                    prec8 = dc8 + 8'd1;
                end
                if ($signed(prec8) > $signed(dc8)) begin
                    zpad8 = prec8 - dc8;
                end
                n_zcnt      = zpad8[5:0];
                n_sign_pend = r_desc.sign_ch != CH_NUL;
                n_content   = dc8 + 8'(n_pfx) + zpad8 + 8'(n_sign_pend);
                n_phase     = PH_PLAN_B;
            end
            PH_PLAN_B: begin
                if (width8 > r_content) begin
                    pad8 = width8 - r_content;
                end
                if (r_desc.left) begin
                    n_rcnt = pad8[5:0];
                end else if (r_desc.zfill) begin
                    n_zcnt = r_zcnt + pad8[5:0];
                end else begin
                    n_lcnt = pad8[5:0];
                end
                total8    = r_content + pad8;
                n_left    = (total8 > 8'(OUT_LIMIT)) ? 7'(OUT_LIMIT) : total8[6:0];
                n_special = total8 == '0;
                n_phase   = PH_EMIT;
            end
            PH_EMIT: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    if (r_special) begin
                        n_code  = CH_NUL;
                        n_cv    = 1'b0;
                        n_bad   = r_desc.bad;
                        n_last  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_cv   = 1'b1;
                        n_bad  = 1'b0;
                        n_last = r_left == 7'd1;
                        n_left = r_left - 7'd1;
                        if (r_left == 7'd1) begin
                            n_phase = PH_IDLE;
                        end
                        if (r_lcnt != '0) begin
                            n_code = CH_SPACE;
                            n_lcnt = r_lcnt - 6'd1;
                        end else if (r_sign_pend) begin
                            n_code      = r_desc.sign_ch;
                            n_sign_pend = 1'b0;
                        end else if (r_pfx != '0) begin
                            n_code = (r_pfx == 2'd2) ? CH_ZERO
                                   : (r_desc.upper ? CH_UX : CH_LX);
                            n_pfx  = r_pfx - 2'd1;
                        end else if (r_zcnt != '0) begin
                            n_code = CH_ZERO;
                            n_zcnt = r_zcnt - 6'd1;
                        end else if (r_dc != '0) begin
                            n_code  = digit_char(r_stack[3:0], r_desc.upper);
                            n_stack = r_stack >> 4;
                            n_dc    = r_dc - DCW'(1);
                        end else begin
                            n_code = CH_SPACE;
                            n_rcnt = r_rcnt - 6'd1;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_valid      = r_ov;
    assign o_char_code  = r_code;
    assign o_char_valid = r_cv;
    assign o_last_char  = r_last;
    assign o_bad_radix  = r_bad;

endmodule

### design/integer_radix_formatter.sv
// printf-style integer formatter: each transaction carries an unsigned magnitude and its
// conversion settings and yields the formatted string one character per output
// transaction, the final one marked by o_last_char; a bad radix or an empty string yields
// a single transaction with o_char_valid low. A short queue decouples input from the
// formatting engine. Digits come from a single divider that retires four quotient bits
// per cycle. An item goes through dispatch, one division per digit, planning, and
// emission of up to 64 characters under output back-pressure, one item at a time.
module integer_radix_formatter import irf_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [63:0]       i_magnitude,
    input  logic [4:0]        i_radix,
    input  logic [5:0]        i_min_width,
    input  logic signed [6:0] i_digits_min,
    input  logic              i_alt_form,
    input  logic              i_left_justify,
    input  logic              i_zero_fill,
    input  logic              i_upper_case,
    input  logic [1:0]        i_sign_select,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_char_code,
    output logic              o_char_valid,
    output logic              o_last_char,
    output logic              o_bad_radix
);

    localparam int QW = VALUE_BITS + $bits(t_desc);

    logic                  q_ready;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] f_value;
    t_desc                 f_desc;
    logic [QW-1:0]         q_out;
    logic [VALUE_BITS-1:0] b_value;
    t_desc                 b_desc;

    irf_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_magnitude    (i_magnitude),
        .i_radix        (i_radix),
        .i_min_width    (i_min_width),
        .i_digits_min   (i_digits_min),
        .i_alt_form     (i_alt_form),
        .i_left_justify (i_left_justify),
        .i_zero_fill    (i_zero_fill),
        .i_upper_case   (i_upper_case),
        .i_sign_select  (i_sign_select),
        .i_q_ready      (q_ready),
        .o_push         (q_push),
        .o_value        (f_value),
        .o_desc         (f_desc)
    );

    irf_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_value, f_desc}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    assign b_value = q_out[QW-1 -: VALUE_BITS];
    assign b_desc  = t_desc'(q_out[$bits(t_desc)-1:0]);

    irf_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_value    (b_value),
        .i_q_desc     (b_desc),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_char_code  (o_char_code),
        .o_char_valid (o_char_valid),
        .o_last_char  (o_last_char),
        .o_bad_radix  (o_bad_radix)
    );

    // error transaction stands alone
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_radix |-> o_last_char && !o_char_valid)
        else $error("bad radix result not a lone empty transaction");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_last_char && o_char_code == CH_NUL)
        else $error("empty result not final or carries a code");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> q_ready)
        else $error("push into full queue");

endmodule

### tb/tb_integer_radix_formatter.sv
module tb_integer_radix_formatter;
    import irf_pkg::*;

    typedef struct {
        logic [63:0]       mag;
        logic [4:0]        radix;
        logic [5:0]        width;
        logic signed [6:0] prec;
        logic              alt;
        logic              left;
        logic              zfill;
        logic              upper;
        logic [1:0]        sign;
    } conv_t;

    typedef struct packed {
        logic [7:0] code;
        logic       cvalid;
        logic       last;
        logic       bad;
    } char_t;

    typedef enum int {
        EXP_MODEL,
        EXP_TEXT,
        EXP_BAD,
        EXP_EMPTY
    } exp_kind_t;

    typedef struct {
        conv_t     conv;
        exp_kind_t kind;
        string     text;
    } row_t;

    localparam int MAX_FIELD = 60;
    localparam int WATCHDOG  = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [63:0]       i_magnitude = '0;
    logic [4:0]        i_radix = '0;
    logic [5:0]        i_min_width = '0;
    logic signed [6:0] i_digits_min = '0;
    logic              i_alt_form = 1'b0;
    logic              i_left_justify = 1'b0;
    logic              i_zero_fill = 1'b0;
    logic              i_upper_case = 1'b0;
    logic [1:0]        i_sign_select = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [7:0]        o_char_code;
    logic              o_char_valid;
    logic              o_last_char;
    logic              o_bad_radix;

    char_t expected_chars[$];
    row_t  rows[$];
    int    errors = 0;
    int    burst_left = 0;
    int    idle_cycles = 0;
    int    stall_mode = 0;
    int    stall_count = 0;

    integer_radix_formatter u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // formatted string of one conversion, queued as expected transactions
    function automatic void predict_chars(input conv_t c);
        logic [63:0] v;
        int          base, width, prec, dc, out_len, alt_len, zpad, lpad, rpad, pad, i;
        logic [3:0]  dig[64];
        logic [7:0]  sc;
        logic [7:0]  line[$];
        string       set;
        char_t       e;
        base = c.radix;
        width = c.width;
        prec = c.prec[6] ? -1 : int'(c.prec);
        dc = 0; alt_len = 0; zpad = 0; lpad = 0; rpad = 0;
        set = c.upper ? "0123456789ABCDEF" : "0123456789abcdef";
        case (c.sign)
            SIGN_PLUS:  sc = CH_PLUS;
            SIGN_SPACE: sc = CH_SPACE;
            SIGN_MINUS: sc = CH_MINUS;
            default:    sc = CH_NUL;
        endcase
        if (base < 2) begin
            e = '{code: CH_NUL, cvalid: 1'b0, last: 1'b1, bad: 1'b1};
            expected_chars.push_back(e);
            return;
        end
        if (base > 16) base = 16;
        if (width > MAX_FIELD) width = MAX_FIELD;
        if (prec > MAX_FIELD) prec = MAX_FIELD;
        if (!(c.mag == 0 && prec == 0)) begin
            v = c.mag;
            do begin
                dig[dc] = 4'(v % 64'(base));
                dc++;
                v = v / 64'(base);
            end while (v != 0 && dc < 64);
        end
        out_len = dc;
        if (c.alt) begin
            if (base == 16) begin
                if (c.mag != 0) begin
                    alt_len = 2;
                    out_len += 2;
                end
            end else if (base == 8) begin
                if (!(dc > 0 && c.mag == 0) && prec <= dc) prec = dc + 1;
            end
        end
        if (dc < prec) begin
            zpad = prec - dc;
            out_len += zpad;
        end
        if (sc != CH_NUL) out_len++;
        if (out_len < width) begin
            pad = width - out_len;
            if (c.left) rpad = pad;
            else if (c.zfill) zpad += pad;
            else lpad = pad;
        end
        repeat (lpad) line.push_back(CH_SPACE);
        if (sc != CH_NUL) line.push_back(sc);
        if (alt_len > 0) begin
            line.push_back(CH_ZERO);
            line.push_back(c.upper ? CH_UX : CH_LX);
        end
        repeat (zpad) line.push_back(CH_ZERO);
        for (i = dc - 1; i >= 0; i--) line.push_back(set[dig[i]]);
        repeat (rpad) line.push_back(CH_SPACE);
        if (line.size() == 0) begin
            e = '{code: CH_NUL, cvalid: 1'b0, last: 1'b1, bad: 1'b0};
            expected_chars.push_back(e);
            return;
        end
        if (line.size() > OUT_LIMIT) line = line[0:OUT_LIMIT-1];
        foreach (line[k]) begin
            e = '{code: line[k], cvalid: 1'b1, last: k == line.size() - 1, bad: 1'b0};
            expected_chars.push_back(e);
        end
    endfunction

    function automatic void push_expected(input row_t r);
        char_t e;
        case (r.kind)
            EXP_BAD: begin
                e = '{code: CH_NUL, cvalid: 1'b0, last: 1'b1, bad: 1'b1};
                expected_chars.push_back(e);
            end
            EXP_EMPTY: begin
                e = '{code: CH_NUL, cvalid: 1'b0, last: 1'b1, bad: 1'b0};
                expected_chars.push_back(e);
            end
            EXP_TEXT: begin
                for (int k = 0; k < r.text.len(); k++) begin
                    e = '{code: r.text[k], cvalid: 1'b1, last: k == r.text.len() - 1,
                          bad: 1'b0};
                    expected_chars.push_back(e);
                end
            end
            default: predict_chars(r.conv);
        endcase
    endfunction

    task automatic add_row(input logic [63:0] mag, input int radix, input int width,
                           input int prec, input bit alt, input bit left, input bit zfill,
                           input bit upper, input logic [1:0] sign, input exp_kind_t kind,
                           input string text);
        row_t r;
        r.conv = '{mag, 5'(radix), 6'(width), 7'(prec), alt, left, zfill, upper, sign};
        r.kind = kind;
        r.text = text;
        rows.push_back(r);
    endtask

    function automatic conv_t random_conv();
        conv_t c;
        case ($urandom_range(0, 3))
            0: c.mag = {$urandom, $urandom};
            1: c.mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: c.mag = 64'($urandom_range(0, 20));
            default: c.mag = '0;
        endcase
        c.radix = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(2, 16))
                                              : 5'($urandom_range(0, 31));
        c.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 24));
        case ($urandom_range(0, 3))
            0: c.prec = 7'($urandom_range(64, 127));
            1: c.prec = 7'($urandom_range(0, 63));
            default: c.prec = 7'($urandom_range(0, 12));
        endcase
        c.alt = 1'($urandom);
        c.left = 1'($urandom);
        c.zfill = 1'($urandom);
        c.upper = 1'($urandom);
        c.sign = 2'($urandom);
        return c;
    endfunction

    task automatic send_conv(input row_t r);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        i_valid        <= 1'b1;
        i_magnitude    <= r.conv.mag;
        i_radix        <= r.conv.radix;
        i_min_width    <= r.conv.width;
        i_digits_min   <= r.conv.prec;
        i_alt_form     <= r.conv.alt;
        i_left_justify <= r.conv.left;
        i_zero_fill    <= r.conv.zfill;
        i_upper_case   <= r.conv.upper;
        i_sign_select  <= r.conv.sign;
        do @(posedge i_clk); while (!o_ready);
        push_expected(r);
        burst_left--;
        if (burst_left == 0) i_valid <= 1'b0;
    endtask

    // receiver stall pattern, mode redrawn from a free-running counter
    always @(posedge i_clk) begin
        stall_count <= stall_count + 1;
        if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // output transaction check
    always @(posedge i_clk) begin
        char_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected transaction code %02h", o_char_code));
            end else begin
                e = expected_chars.pop_front();
                if (o_char_code !== e.code)
                    report($sformatf("char_code %02h exp %02h", o_char_code, e.code));
                if (o_char_valid !== e.cvalid)
                    report($sformatf("char_valid %b exp %b", o_char_valid, e.cvalid));
                if (o_last_char !== e.last)
                    report($sformatf("last_char %b exp %b", o_last_char, e.last));
                if (o_bad_radix !== e.bad)
                    report($sformatf("bad_radix %b exp %b", o_bad_radix, e.bad));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        row_t r;
        add_row(64'd5, 0, 4, -1, 1, 0, 1, 0, SIGN_PLUS, EXP_BAD, "");
        add_row(64'd9, 1, 0, 3, 0, 1, 0, 1, SIGN_NONE, EXP_BAD, "");
        add_row(64'd0, 10, 0, 0, 0, 0, 0, 0, SIGN_NONE, EXP_EMPTY, "");
        add_row(64'd0, 8, 0, 0, 1, 0, 0, 0, SIGN_NONE, EXP_TEXT, "0");
        add_row(64'd0, 10, 0, -1, 0, 0, 0, 0, SIGN_NONE, EXP_TEXT, "0");
        add_row(64'd255, 16, 0, -1, 1, 0, 0, 1, SIGN_NONE, EXP_TEXT, "0XFF");
        add_row(64'd255, 16, 0, -1, 1, 0, 0, 0, SIGN_NONE, EXP_TEXT, "0xff");
        add_row(64'd0, 16, 0, -1, 1, 0, 0, 0, SIGN_NONE, EXP_TEXT, "0");
        add_row(64'd42, 10, 6, -1, 0, 0, 0, 0, SIGN_PLUS, EXP_TEXT, "   +42");
        add_row(64'd42, 10, 5, -1, 0, 1, 1, 0, SIGN_MINUS, EXP_TEXT, "-42  ");
        add_row(64'd42, 10, 6, -1, 0, 0, 1, 0, SIGN_SPACE, EXP_TEXT, " 00042");
        add_row(64'd8, 8, 0, -1, 1, 0, 0, 0, SIGN_NONE, EXP_TEXT, "010");
        add_row(64'd5, 10, 0, -64, 0, 0, 0, 0, SIGN_NONE, EXP_TEXT, "5");
        add_row('1, 31, 0, -1, 0, 0, 0, 1, SIGN_NONE, EXP_TEXT, "FFFFFFFFFFFFFFFF");
        add_row('1, 2, 0, -1, 0, 0, 0, 0, SIGN_NONE, EXP_MODEL, "");
        add_row('1, 2, 63, 63, 1, 0, 1, 0, SIGN_PLUS, EXP_MODEL, "");
        add_row(64'd7, 3, 63, -1, 0, 1, 0, 0, SIGN_SPACE, EXP_MODEL, "");
        add_row(64'd7, 7, 10, 63, 0, 0, 0, 0, SIGN_NONE, EXP_MODEL, "");
        add_row(64'h8000_0000_0000_0000, 16, 63, 0, 1, 0, 0, 1, SIGN_MINUS, EXP_MODEL, "");
        add_row(64'd1234567, 13, 20, 9, 1, 0, 1, 1, SIGN_PLUS, EXP_MODEL, "");

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send_conv(rows[k]);
        repeat (350) begin
            r.conv = random_conv();
            r.kind = EXP_MODEL;
            r.text = "";
            send_conv(r);
        end
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
design/irf_pkg.sv
design/irf_front.sv
design/irf_queue.sv
design/irf_digit_div.sv
design/irf_back.sv
design/integer_radix_formatter.sv
tb/tb_integer_radix_formatter.sv
